### design/ahdf_pkg.sv
// Shared types, constants and pixel arithmetic for the ARGB half downscaler.
// Used by argb_half_downscale_flatten_top; has no dependencies of its own.
`timescale 1ns / 1ps
`default_nettype none

package ahdf_pkg;

  typedef logic [31:0] argb_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_ROW_WIDTH    = 1'b0,
    CFG_HALVE_ENABLE = 1'b1
  } cfg_index_e;

  localparam int unsigned ROW_WIDTH_W     = 13;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd4096;
  localparam argb_t       BYTE_AVG_MASK   = 32'hFEFE_FEFE;
  localparam argb_t       WHITE_PIXEL     = 32'hFFFF_FFFF;
  localparam logic [7:0]  ALPHA_OPAQUE    = 8'hFF;
  localparam logic [7:0]  ALPHA_CLEAR     = 8'h00;

  // Per-byte average without carries leaking between channels.
  function automatic argb_t byte_avg(input argb_t a, input argb_t b);
    byte_avg = ((a ^ b) & BYTE_AVG_MASK) >> 1;
    byte_avg = byte_avg + (a & b);
  endfunction

  // One channel blended over white: (a*s + (255-a)*255) >> 8.
  function automatic logic [7:0] blend_chan(input logic [7:0] a, input logic [7:0] s);
    logic [15:0] sum;
    sum = (16'(a) * 16'(s)) + (16'(ALPHA_OPAQUE - a) * 16'(ALPHA_OPAQUE));
    blend_chan = sum[15:8];
  endfunction

  // Flatten an ARGB pixel over a white background.
  function automatic argb_t flatten(input argb_t p);
    logic [7:0] a;
    a = p[31:24];
    if (a == ALPHA_OPAQUE) begin
      flatten = p;
    end else if (a == ALPHA_CLEAR) begin
      flatten = WHITE_PIXEL;
    end else begin
      flatten = {ALPHA_OPAQUE, blend_chan(a, p[23:16]), blend_chan(a, p[15:8]),
                 blend_chan(a, p[7:0])};
    end
  endfunction

endpackage

`default_nettype wire

### design/argb_half_downscale_flatten_top.sv
// Top level of the ARGB32 2x2 box downscaler with alpha flattening over white.
// Depends on ahdf_pkg for the pixel arithmetic and the register indexes.
`timescale 1ns / 1ps
`default_nettype none

// Usage notes.
// The input channel takes one ARGB32 word per cycle in raster order, with
// frame_start_i marking the first pixel of a frame. The output channel gives
// opaque ARGB32 words, with row_end_o set on the last word of an output row.
// Both channels move a word when valid is high and stall is low.
// With halving on, even rows are reduced to pairwise averages held in a line
// memory of MAX_WIDTH/2 words; each odd column of an odd row yields one word.
// With halving off, every input word is flattened and passed on.
// The line memory read and the pair average are registered in the first
// stage, and the average and blend land in the output register in the
// second. Throughput is one word per cycle while neither channel stalls,
// set by the single read port and single write port of the line memory.
// The input stall only rises when the first stage holds a result and the
// output register is full and stalled, so a word that waits only in the
// output register never blocks the input.
// Reset clears column, row parity, the held left pixel and both pipeline
// valids; row_width returns to 4096 and halving to on. The line memory is not
// cleared and needs no pass: every entry is written on an even row before the
// following odd row reads it.
module argb_half_downscale_flatten_top
  import ahdf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration
  input  wire logic                   cfg_we_i,
  input  wire logic [0:0]             cfg_index_i,
  input  wire logic [ROW_WIDTH_W-1:0] cfg_data_i,
  // input words
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [31:0]            pixel_i,
  input  wire logic                   frame_start_i,
  // output words
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [31:0]                 out_pixel_o,
  output logic                        row_end_o
);

  localparam int unsigned CW   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned LD   = MAX_WIDTH / 2;
  localparam int unsigned IW   = (LD > 1) ? $clog2(LD) : 1;
  localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMPW = ((WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W) + 1;

  // Configuration registers.
  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic                   halve_enable_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q    <= ROW_WIDTH_RESET;
      halve_enable_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_ROW_WIDTH:    row_width_q    <= cfg_data_i;
        CFG_HALVE_ENABLE: halve_enable_q <= cfg_data_i[0];
        default:          ;
      endcase
    end
  end

  // Effective row width: bit 0 ignored, zero acts as two, clamped at MAX_WIDTH.
  logic [CMPW-1:0] width_even;
  logic [CMPW-1:0] eff_width;

  always_comb begin
    width_even = CMPW'({row_width_q[ROW_WIDTH_W-1:1], 1'b0});
    if (width_even == '0) begin
      eff_width = CMPW'(2);
    end else if (width_even > CMPW'(MAX_WIDTH)) begin
      eff_width = CMPW'(MAX_WIDTH);
    end else begin
      eff_width = width_even;
    end
  end

  // Raster position and the left pixel of the current pair.
  logic [CW-1:0] column_q, column_d;
  logic          odd_row_q, odd_row_d;
  argb_t         held_left_q;

  // First stage: line memory read data and the current pair.
  logic  s1_valid_q, s1_valid_d;
  logic  s1_average_q;
  logic  s1_last_q;
  argb_t s1_pair_q;
  argb_t line_rdata_q;

  // Output register.
  logic  out_valid_q;
  argb_t out_pixel_q;
  logic  row_end_q;

  logic  in_fire;
  logic  out_advance;
  logic  s1_load;

  assign out_advance = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !out_advance;
  assign s1_load     = !in_stall_o;
  assign in_fire     = in_valid_i && !in_stall_o;

  // Decode of the accepted word.
  logic [CW-1:0] col_base;
  logic          odd_base;
  logic          last;
  logic [CW-1:0] col_pair;
  logic          idx_ok;
  logic          col_odd;
  logic          emit;
  logic          line_we;
  logic          line_re;
  logic [IW-1:0] line_addr;
  argb_t         pair;

  always_comb begin
    col_base  = frame_start_i ? '0 : column_q;
    odd_base  = frame_start_i ? 1'b0 : odd_row_q;
    last      = (CMPW'(col_base) + CMPW'(1)) >= eff_width;
    col_pair  = col_base >> 1;
    idx_ok    = col_pair < CW'(LD);
    col_odd   = col_base[0];
    line_addr = col_pair[IW-1:0];
    pair      = byte_avg(held_left_q, pixel_i);
    line_we   = in_fire && halve_enable_q && col_odd && !odd_base && idx_ok;
    line_re   = in_fire && halve_enable_q && col_odd && odd_base && idx_ok;
    emit      = halve_enable_q ? (col_odd && odd_base && idx_ok) : 1'b1;
    column_d  = last ? '0 : CW'(col_base + 1'b1);
    odd_row_d = last ? !odd_base : odd_base;
    s1_valid_d = in_fire && emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q    <= '0;
      odd_row_q   <= 1'b0;
      held_left_q <= '0;
    end else if (in_fire) begin
      column_q  <= column_d;
      odd_row_q <= odd_row_d;
      if (halve_enable_q && !col_odd) begin
        held_left_q <= pixel_i;
      end
    end
  end

  // Line memory of pair averages from the even row.
  argb_t line_mem [LD];

  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem[line_addr] <= pair;
    end
    if (line_re) begin
      line_rdata_q <= line_mem[line_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_load) begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load && in_fire) begin
      s1_average_q <= halve_enable_q;
      s1_last_q    <= last;
      s1_pair_q    <= halve_enable_q ? pair : pixel_i;
    end
  end

  // Second stage: vertical average, then flatten over white.
  argb_t blend_src;
  argb_t out_pixel_d;

  always_comb begin
    blend_src   = s1_average_q ? byte_avg(line_rdata_q, s1_pair_q) : s1_pair_q;
    out_pixel_d = flatten(blend_src);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && s1_valid_q) begin
      out_pixel_q <= out_pixel_d;
      row_end_q   <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_pixel_o = out_pixel_q;
  assign row_end_o   = row_end_q;

  // The input only stalls behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_q && out_stall_i))
    else $error("input stalled without a stalled output word");

  // Without halving every accepted word reaches the first stage.
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !halve_enable_q) |=> s1_valid_q)
    else $error("accepted word lost with halving off");

  // An even row writes the line memory and an odd row reads it, never both.
  a_line_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(line_we && line_re))
    else $error("line memory read and written by one word");

  // The column stays inside the widest row.
  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(column_q) < CMPW'(MAX_WIDTH))
    else $error("column beyond the widest row");

endmodule

`default_nettype wire

### dv/tb_argb_half_downscale_flatten_top.sv
// Self-checking testbench for argb_half_downscale_flatten_top.
// Needs ahdf_pkg (types, register indexes) and the top level; an internal
// predictor builds the expected output words, which are checked in order.
`timescale 1ns / 1ps

module tb_argb_half_downscale_flatten_top
  import ahdf_pkg::*;
();

  localparam int unsigned LINE_MAX   = 4096;
  localparam int unsigned PAIR_SLOTS = LINE_MAX / 2;
  localparam int unsigned PAIR_AW    = $clog2(PAIR_SLOTS);
  // A little more than the two-stage pipeline, so that words which produce
  // no output have left the block before the registers change.
  localparam int unsigned PIPE_SLACK = 6;

  // One expected output word: the opaque pixel and the end-of-row flag.
  typedef struct packed {
    argb_t pixel;
    logic  row_end;
  } out_word_t;

  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [0:0]             cfg_index_i   = CFG_ROW_WIDTH;
  logic [ROW_WIDTH_W-1:0] cfg_data_i    = '0;
  logic                   in_valid_i    = 1'b0;
  logic                   in_stall_o;
  logic [31:0]            pixel_i       = '0;
  logic                   frame_start_i = 1'b0;
  logic                   out_valid_o;
  logic                   out_stall_i   = 1'b0;
  logic [31:0]            out_pixel_o;
  logic                   row_end_o;

  argb_half_downscale_flatten_top #(
    .MAX_WIDTH(LINE_MAX)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .pixel_i      (pixel_i),
    .frame_start_i(frame_start_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_pixel_o  (out_pixel_o),
    .row_end_o    (row_end_o)
  );

  // Predictor state, kept apart from the block. The values match what the
  // block holds right after reset.
  logic [ROW_WIDTH_W-1:0] row_width_q = ROW_WIDTH_RESET;
  logic                   halve_q     = 1'b1;
  argb_t                  pair_line_q [0:PAIR_SLOTS-1];
  argb_t                  held_left_q = '0;
  logic [12:0]            col_q       = '0;
  logic                   odd_row_q   = 1'b0;

  // Output words still owed by the block, oldest first.
  out_word_t expected_words[$];

  // Percent chance per cycle that the sender holds off, and that the
  // receiver stalls the output channel.
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  int unsigned errors        = 0;
  int unsigned pixels_sent   = 0;
  int unsigned words_checked = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop well beyond the slowest legal run of this stimulus.
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // Floor of the mean of each byte pair; bytes never carry into each other.
  function automatic argb_t mean_bytes(input argb_t a, input argb_t b);
    argb_t    r;
    logic [8:0] s;
    int       k;
    for (k = 0; k < 4; k++) begin
      s = {1'b0, a[8*k +: 8]} + {1'b0, b[8*k +: 8]};
      r[8*k +: 8] = s[8:1];
    end
    return r;
  endfunction

  // Composite a pixel over white. Fully opaque pixels are left alone, fully
  // clear ones turn white, and the rest blend each colour channel.
  function automatic argb_t over_white(input argb_t p);
    argb_t       r;
    logic [7:0]  alpha;
    logic [15:0] acc;
    int          k;
    alpha = p[31:24];
    if (alpha == ALPHA_OPAQUE) return p;
    if (alpha == ALPHA_CLEAR) return WHITE_PIXEL;
    r[31:24] = ALPHA_OPAQUE;
    for (k = 0; k < 3; k++) begin
      acc = alpha * p[8*k +: 8] + (ALPHA_OPAQUE - alpha) * ALPHA_OPAQUE;
      r[8*k +: 8] = acc[15:8];
    end
    return r;
  endfunction

  // Row width as the block uses it: even, at least 2, at most the line size.
  function automatic int unsigned active_width();
    int unsigned w;
    w = {row_width_q[ROW_WIDTH_W-1:1], 1'b0};
    if (w == 0) w = 2;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  // Advance the predictor by one accepted input word and queue the output
  // word it causes, if any.
  function automatic void predict_downscale(input argb_t pix, input logic fs);
    int unsigned wid;
    logic        last;
    argb_t       pair;
    wid = active_width();
    if (fs) begin
      col_q     = '0;
      odd_row_q = 1'b0;
    end
    last = (col_q + 32'd1 >= wid);
    if (halve_q) begin
      if (!col_q[0]) begin
        held_left_q = pix;
      end else begin
        pair = mean_bytes(held_left_q, pix);
        if (!odd_row_q) begin
          pair_line_q[col_q[PAIR_AW:1]] = pair;
        end else begin
          expected_words.push_back('{
            pixel:   over_white(mean_bytes(pair_line_q[col_q[PAIR_AW:1]], pair)),
            row_end: last});
        end
      end
    end else begin
      expected_words.push_back('{pixel: over_white(pix), row_end: last});
    end
    if (last) begin
      col_q     = '0;
      odd_row_q = ~odd_row_q;
    end else begin
      col_q = col_q + 1'b1;
    end
  endfunction

  // Random pixel with fully clear, fully opaque and saturated colours
  // showing up often.
  function automatic argb_t random_argb();
    argb_t p;
    p = $urandom;
    case ($urandom_range(7))
      0: begin
        p[31:24] = ALPHA_CLEAR;
      end
      1, 2: begin
        p[31:24] = ALPHA_OPAQUE;
      end
      3: begin
        p[23:0] = $urandom_range(1) ? 24'hFF_FFFF : 24'h00_0000;
      end
      default: begin
      end
    endcase
    return p;
  endfunction

  // Receiver: the stall changes only at the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Checker: every word the block hands over is matched against the oldest
  // expected word, field by field.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, got pixel %h row_end %b",
                 $time, out_pixel_o, row_end_o);
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (out_pixel_o !== want.pixel) begin
          errors++;
          $display("%0t: out_pixel mismatch: expected %h, got %h",
                   $time, want.pixel, out_pixel_o);
        end
        if (row_end_o !== want.row_end) begin
          errors++;
          $display("%0t: row_end mismatch: expected %b, got %b (pixel %h)",
                   $time, want.row_end, row_end_o, out_pixel_o);
        end
      end
    end
  end

  // Offer one word on the input channel, after a random hold-off, and keep
  // it steady until the block takes it. The predictor runs on acceptance.
  task automatic send_pixel(input argb_t pix, input logic fs);
    while ($urandom_range(99) < gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    pixel_i       <= pix;
    frame_start_i <= fs;
    do @(posedge clk_i); while (in_stall_o);
    pixels_sent++;
    predict_downscale(pix, fs);
  endtask

  // A run of random words; the first one may open a new frame.
  task automatic send_run(input int unsigned count, input logic first_fs);
    int unsigned i;
    for (i = 0; i < count; i++) begin
      send_pixel(random_argb(), first_fs && (i == 0));
    end
  endtask

  // Stop sending and wait until every owed word has come out, then wait out
  // the pipeline slack for words that make no output.
  task automatic drain_pipeline();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (PIPE_SLACK) @(posedge clk_i);
  endtask

  // Write both registers; only called with the block drained.
  task automatic program_registers(input logic [ROW_WIDTH_W-1:0] width,
                                   input logic halve);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_ROW_WIDTH;
    cfg_data_i  <= width;
    @(negedge clk_i);
    cfg_index_i <= CFG_HALVE_ENABLE;
    cfg_data_i  <= {{(ROW_WIDTH_W-1){1'b0}}, halve};
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    row_width_q = width;
    halve_q     = halve;
  endtask

  // Registers as they come out of reset: part of a wide even row with
  // halving on, starting from the reset column and row state without a
  // frame start. No word may come out yet.
  task automatic test_reset_defaults();
    gap_pct   = 0;
    stall_pct = 0;
    send_run(40, 1'b0);
    drain_pipeline();
  endtask

  // Flatten only: opaque, clear, nearly clear, nearly opaque and half alpha
  // against extreme and mixed colours.
  task automatic test_alpha_flatten();
    argb_t cases [12] = '{
      32'h0012_3456, 32'hFF12_3456, 32'hFFFF_FFFF, 32'h0000_0000,
      32'h01FF_FFFF, 32'h0100_0000, 32'hFE00_0000, 32'hFEFF_FFFF,
      32'h80FF_00FF, 32'h7F00_FF80, 32'h4080_8080, 32'hC0A5_5AC3};
    gap_pct   = 31;
    stall_pct = 31;
    program_registers(13'd8, 1'b0);
    foreach (cases[i]) begin
      send_pixel(cases[i], i == 0);
    end
    drain_pipeline();
  endtask

  // 2x2 averages at width 4: all-white, all-black, odd low bits that round
  // down, and averages that land on partial alpha.
  task automatic test_box_average();
    argb_t cases [16] = '{
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000,
      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0101_0101,
      32'h0101_0101, 32'h0000_0000, 32'hFF00_FF00, 32'h00FF_00FF,
      32'h0101_0101, 32'h0101_0101, 32'h8080_8080, 32'h7F7F_7F7F};
    gap_pct   = 80;
    stall_pct = 0;
    program_registers(13'd4, 1'b1);
    foreach (cases[i]) begin
      send_pixel(cases[i], i == 0);
    end
    drain_pipeline();
  endtask

  // Width codes: zero and one act as two, odd widths drop their low bit,
  // and the all-ones code gives a wide row with no early row end.
  task automatic test_width_codes();
    gap_pct   = 0;
    stall_pct = 80;
    program_registers(13'd0, 1'b1);
    send_run(4, 1'b1);
    drain_pipeline();
    program_registers(13'd1, 1'b1);
    send_run(4, 1'b1);
    drain_pipeline();
    program_registers(13'd3, 1'b1);
    send_run(8, 1'b1);
    drain_pipeline();
    program_registers(13'h1FFF, 1'b0);
    gap_pct   = 0;
    stall_pct = 0;
    send_run(40, 1'b1);
    drain_pipeline();
  endtask

  // Frame start in the middle of an odd row and in the middle of an even
  // row: both restart at the top of a frame.
  task automatic test_frame_restart();
    gap_pct   = 31;
    stall_pct = 31;
    program_registers(13'd8, 1'b1);
    send_run(11, 1'b1);
    send_run(16, 1'b1);
    send_run(5, 1'b1);
    send_run(16, 1'b1);
    drain_pipeline();
  endtask

  // Shrinking the width while the column is past the new end makes the
  // next word close its row at once. Done with halving off, so no
  // unwritten line entry is ever read.
  task automatic test_width_shrink();
    gap_pct   = 0;
    stall_pct = 31;
    program_registers(13'd20, 1'b0);
    send_run(15, 1'b1);
    drain_pipeline();
    program_registers(13'd6, 1'b0);
    send_run(10, 1'b0);
    drain_pipeline();
  endtask

  // Random frames in four pacing phases. Most frames are whole row pairs at
  // small widths; some are cut short and restarted by the next frame start.
  // Now and then the sender waits for the output side to catch up.
  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned sent;
    int unsigned rows;
    int unsigned count;
    logic [ROW_WIDTH_W-1:0] width;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          gap_pct = 0;  stall_pct = 0;
        end
        1: begin
          gap_pct = 80; stall_pct = 0;
        end
        2: begin
          gap_pct = 0;  stall_pct = 80;
        end
        default: begin
          gap_pct = 31; stall_pct = 31;
        end
      endcase
      case ($urandom_range(9))
        0: width = ROW_WIDTH_W'($urandom_range(0, 3));
        1: width = ROW_WIDTH_W'($urandom_range(32, 64));
        default: width = ROW_WIDTH_W'($urandom_range(2, 24));
      endcase
      program_registers(width, $urandom_range(3) != 0);
      sent = 0;
      while (sent < 48) begin
        rows  = (active_width() > 24) ? 2 : 2 * $urandom_range(1, 2);
        count = rows * active_width();
        if ($urandom_range(9) == 0) count = $urandom_range(1, count - 1);
        send_run(count, 1'b1);
        sent += count;
        if ($urandom_range(5) == 0) drain_pipeline();
      end
      drain_pipeline();
    end
  endtask

  // Reset once, then the tests in turn. Each test leaves the block drained,
  // so register writes always land while the block is idle.
  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_alpha_flatten();
    test_box_average();
    test_width_codes();
    test_frame_restart();
    test_width_shrink();
    test_random_traffic();
    drain_pipeline();
    $display("Sent %0d pixels, checked %0d output words, %0d mismatches.",
             pixels_sent, words_checked, errors);
    $display("Covered reset widths, width clamping, restarts, halving on/off, all pacings.");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
